@@ sv/ccd_pkg.sv @@
`timescale 1ns / 1ps

package ccd_pkg;

   // Field widths fixed by the interface.
   localparam int CMD_W    = 2;
   localparam int AMOUNT_W = 16;
   localparam int VALUE_W  = 12;
   localparam int QTY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int LEFT_W   = 12;

   // Eight denomination registers, addressed by a three-bit index.
   localparam int SLOTS  = 8;
   localparam int SLOT_W = 3;

   // One quotient bit per divider step.
   localparam int DIV_STEPS  = AMOUNT_W;
   localparam int DIV_STEP_W = 4;

   typedef logic [VALUE_W-1:0] denom_type;
   typedef denom_type [SLOTS-1:0] denom_array_type;

   // Denomination values after reset, register 0 in the low bits.
   localparam denom_array_type DENOM_RESET = {
      12'd1000, 12'd500, 12'd200, 12'd100, 12'd50, 12'd20, 12'd10, 12'd5
   };

   typedef enum logic [CMD_W-1:0] {
      CMD_DISPENSE = 2'd0,
      CMD_DEPOSIT  = 2'd1,
      CMD_RESTOCK  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_SHORT     = 2'd1,
      STAT_INVALID   = 2'd2,
      STAT_RESTOCKED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SETUP,
      ST_DIV_WAIT,
      ST_DIV_END,
      ST_PAY,
      ST_DEPOSIT,
      ST_RESTOCK
   } state_type;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ sv/ccd_csr.sv @@
`timescale 1ns / 1ps

module ccd_csr
   import ccd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [SLOT_W-1:0] csr_index,
   input  logic [VALUE_W-1:0] csr_data,
   output denom_array_type denom_values
);

   denom_array_type denom_ff;
   denom_array_type denom_in;

   // Always ready; software must write while the block is idle; unchecked.
   assign csr_ready = 1'b1;

   always_comb begin
      denom_in = denom_ff;
      if (csr_valid) begin
         denom_in[csr_index] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         denom_ff <= DENOM_RESET;
      end else begin
         denom_ff <= denom_in;
      end
   end

   assign denom_values = denom_ff;

endmodule

@@ sv/ccd_divider.sv @@
`timescale 1ns / 1ps

module ccd_divider
   import ccd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [AMOUNT_W-1:0] dividend,
   input  logic [VALUE_W-1:0]  divisor,
   output div_stat_type        stat,
   output logic [AMOUNT_W-1:0] quotient,
   output logic [VALUE_W-1:0]  remainder
);

   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [AMOUNT_W-1:0]   quot_ff, quot_in;
   logic [VALUE_W-1:0]    rem_ff, rem_in;
   logic [VALUE_W-1:0]    divisor_ff, divisor_in;
   logic [VALUE_W:0]      trial;
   logic [VALUE_W:0]      diff;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign trial = {rem_ff, quot_ff[AMOUNT_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      active_in  = active_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         active_in  = 1'b1;
         step_in    = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (active_ff) begin
         if (!diff[VALUE_W]) begin
            rem_in  = diff[VALUE_W-1:0];
            quot_in = {quot_ff[AMOUNT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[VALUE_W-1:0];
            quot_in = {quot_ff[AMOUNT_W-2:0], 1'b0};
         end
         step_in = step_ff + DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy = active_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/coin_change_dispenser.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                          Handshake
// request   req_cmd, req_amount                            start and not busy
// response  rsp_status, rsp_coin_value, rsp_coin_quantity, rsp_valid strobe, one cycle
//           rsp_leftover, rsp_last
// csr       csr_index, csr_data                            csr_valid and csr_ready
//
// A dispense walks the denominations from the top register down through one shared
// 16-step restoring divider, skipping zero registers, then makes one decision and
// pays out the used denominations from the top down. A deposit scans the registers
// from register 0 up for a match, a restock writes the count of every register.
// Reset is synchronous and clears all counts and control at once. Results are
// strobed and cannot be stalled.

module coin_change_dispenser
   import ccd_pkg::*;
#(
   parameter int NUM_DENOMS    = 8,
   parameter int COUNT_BITS    = 16,
   parameter int DEFAULT_COUNT = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [AMOUNT_W-1:0] req_amount,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_coin_value,
   output logic [QTY_W-1:0]    rsp_coin_quantity,
   output logic [LEFT_W-1:0]   rsp_leftover,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SLOT_W-1:0]   csr_index,
   input  logic [VALUE_W-1:0]  csr_data
);

   localparam int IDX_W = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
   localparam int NU_W  = $clog2(NUM_DENOMS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DENOMS - 1);
   localparam longint unsigned COUNT_MAX_L = (64'd1 << COUNT_BITS) - 64'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] DEF_CNT =
      (64'(DEFAULT_COUNT) > COUNT_MAX_L) ? COUNT_BITS'(COUNT_MAX_L)
                                         : COUNT_BITS'(DEFAULT_COUNT);
   localparam logic [31:0] DEF_WIDE = 32'(DEF_CNT);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [AMOUNT_W-1:0]   work_ff, work_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic [NU_W-1:0]       nused_ff, nused_in;
   logic                  enough_ff, enough_in;

   logic [COUNT_BITS-1:0] counts_ff [NUM_DENOMS];
   logic [AMOUNT_W-1:0]   need_ff [NUM_DENOMS];
   logic                  cnt_we;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  need_we;
   logic [AMOUNT_W-1:0]   need_wdata;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [QTY_W-1:0]      rsp_qty_ff, rsp_qty_in;
   logic [LEFT_W-1:0]     rsp_left_ff, rsp_left_in;
   logic                  rsp_last_ff, rsp_last_in;

   denom_array_type       denom_values;
   denom_type             cur_denom;
   logic [COUNT_BITS-1:0] cur_count;
   logic [AMOUNT_W-1:0]   cur_need;
   logic [COUNT_BITS-1:0] inc_count;
   logic [31:0]           inc_wide;
   logic                  dep_match;
   logic                  need_short;

   logic                  div_start;
   div_stat_type          div_stat;
   logic [AMOUNT_W-1:0]   div_quot;
   logic [VALUE_W-1:0]    div_rem;

   ccd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .denom_values (denom_values)
   );

   ccd_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (work_ff),
      .divisor   (cur_denom),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Values of the denomination under the index.
   assign cur_denom  = denom_values[SLOT_W'(idx_ff)];
   assign cur_count  = counts_ff[idx_ff];
   assign cur_need   = need_ff[idx_ff];
   assign inc_count  = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
   assign inc_wide   = 32'(inc_count);
   assign dep_match  = (cur_denom != '0) && (AMOUNT_W'(cur_denom) == work_ff);
   assign need_short = 32'(div_quot) > 32'(cur_count);

   assign busy = (state_ff != ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_DISPENSE: state_in = ST_DIV_SETUP;
                  CMD_DEPOSIT:  state_in = ST_DEPOSIT;
                  CMD_RESTOCK:  state_in = ST_RESTOCK;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV_SETUP: begin
            if (cur_denom != '0) begin
               state_in = ST_DIV_WAIT;
            end else if (idx_ff == '0) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = (idx_ff == '0) ? ST_DIV_END : ST_DIV_SETUP;
            end
         end
         ST_DIV_END: begin
            state_in = (!enough_ff || nused_ff == '0) ? ST_IDLE : ST_PAY;
         end
         ST_PAY: begin
            if ((cur_need != '0 && nused_ff == NU_W'(1)) || idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEPOSIT: begin
            if (dep_match || idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESTOCK: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control, count writes and result registers.
   always_comb begin
      idx_in        = idx_ff;
      work_in       = work_ff;
      left_in       = left_ff;
      nused_in      = nused_ff;
      enough_in     = enough_ff;
      cnt_we        = 1'b0;
      cnt_wdata     = cur_count;
      need_we       = 1'b0;
      need_wdata    = div_quot;
      div_start     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            work_in   = req_amount;
            enough_in = 1'b1;
            nused_in  = '0;
            idx_in    = (req_cmd == CMD_DISPENSE) ? LAST_IDX : '0;
         end
         ST_DIV_SETUP: begin
            // A zero denomination is skipped with no coins needed.
            if (cur_denom != '0) begin
               div_start = 1'b1;
            end else begin
               need_we    = 1'b1;
               need_wdata = '0;
               if (idx_ff != '0) begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               need_we = 1'b1;
               work_in = AMOUNT_W'(div_rem);
               if (need_short) begin
                  enough_in = 1'b0;
               end
               if (div_quot != '0) begin
                  nused_in = nused_ff + NU_W'(1);
               end
               if (idx_ff != '0) begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         ST_DIV_END: begin
            left_in       = (work_ff > AMOUNT_W'(4095)) ? '1 : work_ff[LEFT_W-1:0];
            idx_in        = LAST_IDX;
            rsp_value_in  = '0;
            rsp_qty_in    = '0;
            rsp_left_in   = (work_ff > AMOUNT_W'(4095)) ? '1 : work_ff[LEFT_W-1:0];
            rsp_last_in   = 1'b1;
            if (!enough_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_SHORT;
            end else if (nused_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
            end
         end
         ST_PAY: begin
            // Walk the registers from the top down and pay out each used denomination, highest first.
            if (cur_need != '0) begin
               cnt_we        = 1'b1;
               cnt_wdata     = cur_count - COUNT_BITS'(cur_need);
               nused_in      = nused_ff - NU_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_value_in  = cur_denom;
               rsp_qty_in    = cur_need;
               rsp_left_in   = left_ff;
               rsp_last_in   = (nused_ff == NU_W'(1));
            end
            if (idx_ff != '0) begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_DEPOSIT: begin
            rsp_left_in = '0;
            rsp_last_in = 1'b1;
            if (dep_match) begin
               cnt_we        = 1'b1;
               cnt_wdata     = inc_count;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_value_in  = cur_denom;
               rsp_qty_in    = inc_wide[QTY_W-1:0];
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_INVALID;
               rsp_value_in  = '0;
               rsp_qty_in    = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_RESTOCK: begin
            cnt_we    = 1'b1;
            cnt_wdata = DEF_CNT;
            if (idx_ff == LAST_IDX) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_RESTOCKED;
               rsp_value_in  = '0;
               rsp_qty_in    = DEF_WIDE[QTY_W-1:0];
               rsp_left_in   = '0;
               rsp_last_in   = 1'b1;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      work_ff       <= work_in;
      left_ff       <= left_in;
      nused_ff      <= nused_in;
      enough_ff     <= enough_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Coin counts, cleared by reset, at most one entry written per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DENOMS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         counts_ff[idx_ff] <= cnt_wdata;
      end
   end

   // Needed quantity per denomination from the greedy split.
   always_ff @(posedge clock) begin
      if (need_we) begin
         need_ff[idx_ff] <= need_wdata;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_coin_value    = rsp_value_ff;
   assign rsp_coin_quantity = rsp_qty_ff;
   assign rsp_leftover      = rsp_left_ff;
   assign rsp_last          = rsp_last_ff;

   // A result that is not the last one is followed by more payout work.
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while sequencer is idle");

   // Shortage, invalid coin and restock each give a single result.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_last)
      else $error("error or restock result without last mark");

   // The divider is never restarted in the middle of a division.
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // While waiting, the divider is either working or reporting completion.
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_WAIT |-> div_stat.busy || div_stat.done)
      else $error("waiting on a divider that is not running");

endmodule

@@ tb/sv/ccd_payout_checker.sv @@
`timescale 1ns / 1ps

module ccd_payout_checker
   import ccd_pkg::*;
#(
   parameter int NUM_DENOMS    = 8,
   parameter int COUNT_BITS    = 16,
   parameter int DEFAULT_COUNT = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [VALUE_W-1:0]  rsp_coin_value,
   input  logic [QTY_W-1:0]    rsp_coin_quantity,
   input  logic [LEFT_W-1:0]   rsp_leftover,
   input  logic                rsp_last,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [SLOT_W-1:0]   csr_index,
   input  logic [VALUE_W-1:0]  csr_data,
   output int                  pending_count,
   output int                  error_count
);

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam longint unsigned LEFT_MAX  = (64'd1 << LEFT_W) - 64'd1;

   typedef struct {
      status_type        status;
      denom_type         coin_value;
      logic [QTY_W-1:0]  coin_quantity;
      logic [LEFT_W-1:0] leftover;
      logic              last;
   } payout_type;

   // Shadow of the block: denomination registers and coin stock.
   denom_array_type denom_regs;
   longint unsigned coin_stock [SLOTS];
   payout_type      expected_payouts [$];
   int              mismatches = 0;

   // Appends one expected result at the tail of the queue.
   function automatic void add_expected(input payout_type p);
      expected_payouts.insert(expected_payouts.size(), p);
   endfunction

   // Works out the results of one request and updates the shadow stock.
   function automatic void predict_change(input logic [CMD_W-1:0]    cmd,
                                          input logic [AMOUNT_W-1:0] amount);
      longint unsigned need [SLOTS];
      longint unsigned rest;
      longint unsigned fill;
      logic            enough;
      logic            matched;
      int              used;
      int              given;
      int              i;
      payout_type      p;
      rest             = amount;
      enough           = 1'b1;
      matched          = 1'b0;
      used             = 0;
      given            = 0;
      p.status         = STAT_OK;
      p.coin_value     = '0;
      p.coin_quantity  = '0;
      p.leftover       = '0;
      p.last           = 1'b1;
      case (cmd)
         CMD_DISPENSE: begin
            // Greedy split from the top register down; zero registers are skipped.
            for (i = NUM_DENOMS - 1; i >= 0; i--) begin
               need[i] = 0;
               if (denom_regs[i] != 0) begin
                  need[i] = rest / denom_regs[i];
                  rest    = rest - need[i] * denom_regs[i];
               end
               if (need[i] > coin_stock[i]) enough = 1'b0;
               if (need[i] != 0) used++;
            end
            p.leftover = (rest > LEFT_MAX) ? LEFT_W'(LEFT_MAX) : LEFT_W'(rest);
            if (!enough) begin
               p.status = STAT_SHORT;
               add_expected(p);
            end else if (used == 0) begin
               add_expected(p);
            end else begin
               // Paid out: one transaction per denomination actually used.
               for (i = NUM_DENOMS - 1; i >= 0; i--) begin
                  if (need[i] != 0) begin
                     coin_stock[i]   = coin_stock[i] - need[i];
                     given++;
                     p.coin_value    = denom_regs[i];
                     p.coin_quantity = QTY_W'(need[i]);
                     p.last          = (given == used);
                     add_expected(p);
                  end
               end
            end
         end
         CMD_DEPOSIT: begin
            // The lowest matching nonzero register takes the coin.
            for (i = 0; i < NUM_DENOMS; i++) begin
               if (!matched && denom_regs[i] != 0 && denom_regs[i] == amount) begin
                  matched = 1'b1;
                  if (coin_stock[i] < COUNT_MAX) coin_stock[i] = coin_stock[i] + 1;
                  p.coin_value    = denom_regs[i];
                  p.coin_quantity = QTY_W'(coin_stock[i]);
               end
            end
            if (!matched) p.status = STAT_INVALID;
            add_expected(p);
         end
         CMD_RESTOCK: begin
            fill = DEFAULT_COUNT;
            if (fill > COUNT_MAX) fill = COUNT_MAX;
            for (i = 0; i < SLOTS; i++) coin_stock[i] = fill;
            p.status        = STAT_RESTOCKED;
            p.coin_quantity = QTY_W'(fill);
            add_expected(p);
         end
         default: begin
            // The unused command is dropped without a result.
         end
      endcase
   endfunction

   function automatic void check_field(input string           name,
                                       input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Results are retired before new requests are predicted in the same cycle.
   always @(posedge clock) begin : watch
      payout_type want;
      if (reset) begin
         denom_regs = DENOM_RESET;
         foreach (coin_stock[i]) coin_stock[i] = 0;
         expected_payouts.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_payouts.size() == 0) begin
               $display({"%0t ns: unexpected result, expected none, actual status %0d",
                         " value %0d quantity %0d leftover %0d last %0d"},
                        $time, rsp_status, rsp_coin_value, rsp_coin_quantity,
                        rsp_leftover, rsp_last);
               mismatches++;
            end else begin
               want = expected_payouts.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("coin_value", want.coin_value, rsp_coin_value);
               check_field("coin_quantity", want.coin_quantity, rsp_coin_quantity);
               check_field("leftover", want.leftover, rsp_leftover);
               check_field("last", want.last, rsp_last);
            end
         end
         if (csr_valid && csr_ready) denom_regs[csr_index] = csr_data;
         if (start && !busy) predict_change(req_cmd, req_amount);
      end
      pending_count <= expected_payouts.size();
      error_count   <= mismatches;
   end

endmodule

@@ tb/sv/tb_coin_change_dispenser.sv @@
`timescale 1ns / 1ps

module tb_coin_change_dispenser;
   import ccd_pkg::*;

   localparam int NUM_DENOMS        = 8;
   localparam int COUNT_BITS        = 16;
   localparam int DEFAULT_COUNT     = 20;
   localparam int CLK_HALF          = 4;
   localparam int RESET_CYCLES      = 12;
   localparam int SETTLE_CYCLES     = 200;
   localparam int WATCHDOG_LIMIT    = 5000;
   localparam int EXTRA_DEPOSITS    = 3;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd     = '0;
   logic [AMOUNT_W-1:0] req_amount  = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_coin_value;
   logic [QTY_W-1:0]    rsp_coin_quantity;
   logic [LEFT_W-1:0]   rsp_leftover;
   logic                rsp_last;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [SLOT_W-1:0]   csr_index   = '0;
   logic [VALUE_W-1:0]  csr_data    = '0;

   int              pending_count;
   int              error_count;
   int              quiet_cycles    = 0;
   int              sender_idle_pct = 0;
   denom_array_type loaded_denoms   = DENOM_RESET;

   always #(CLK_HALF) clock = ~clock;

   coin_change_dispenser #(
      .NUM_DENOMS    (NUM_DENOMS),
      .COUNT_BITS    (COUNT_BITS),
      .DEFAULT_COUNT (DEFAULT_COUNT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_coin_value    (rsp_coin_value),
      .rsp_coin_quantity (rsp_coin_quantity),
      .rsp_leftover      (rsp_leftover),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   ccd_payout_checker #(
      .NUM_DENOMS    (NUM_DENOMS),
      .COUNT_BITS    (COUNT_BITS),
      .DEFAULT_COUNT (DEFAULT_COUNT)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_coin_value    (rsp_coin_value),
      .rsp_coin_quantity (rsp_coin_quantity),
      .rsp_leftover      (rsp_leftover),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .pending_count     (pending_count),
      .error_count       (error_count)
   );

   // Any accepted transaction on any channel restarts the watchdog.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Holds off the next request until every expected result has come back.
   // A wait before the check lets the checker's registered count catch up with the last request.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Denominations change only with the block idle, so settle first.
   task automatic load_denoms(input denom_array_type vals);
      int i;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (i = 0; i < SLOTS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= SLOT_W'(i);
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid     <= 1'b0;
      loaded_denoms  = vals;
   endtask

   // Start stays high across back-to-back requests; gaps are random per cycle.
   task automatic send_request(input logic [CMD_W-1:0]    cmd,
                               input logic [AMOUNT_W-1:0] amount);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_amount <= amount;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Mostly well-formed traffic: real coin values and payable amounts.
   task automatic send_random_request(output bit counted);
      int                  pick;
      int                  i;
      longint unsigned     total;
      logic [AMOUNT_W-1:0] amount;
      pick    = $urandom_range(99);
      amount  = AMOUNT_W'($urandom);
      counted = 1'b1;
      if (pick < 6) begin
         send_request(CMD_RESTOCK, amount);
      end else if (pick < 10) begin
         counted = 1'b0;
         send_request(CMD_UNUSED, amount);
      end else if (pick < 40) begin
         if ($urandom_range(3) != 0) amount = AMOUNT_W'(loaded_denoms[$urandom_range(SLOTS-1)]);
         send_request(CMD_DEPOSIT, amount);
      end else begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            total = 0;
            for (i = 0; i < SLOTS; i++) begin
               if ($urandom_range(1) != 0) total += loaded_denoms[i] * $urandom_range(2);
            end
            amount = AMOUNT_W'(total);
         end else if (pick < 8) begin
            amount = AMOUNT_W'($urandom_range(2000));
         end
         send_request(CMD_DISPENSE, amount);
      end
   endtask

   task automatic run_random(input int count);
      int done_items;
      bit counted;
      done_items = 0;
      while (done_items < count) begin
         if ($urandom_range(15) == 0) wait_drained();
         send_random_request(counted);
         if (counted) done_items++;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Standard coin set; the sender idles now and then.
      sender_idle_pct = 18;
      load_denoms(DENOM_RESET);
      send_request(CMD_DISPENSE, 16'd0);      // nothing to give
      send_request(CMD_DISPENSE, 16'd35);     // empty stock, so a shortage
      send_request(CMD_DEPOSIT, 16'd7);       // no such coin
      send_request(CMD_DEPOSIT, 16'd0);       // zero never matches
      send_request(CMD_UNUSED, 16'hFFFF);     // dropped, no result
      send_request(CMD_RESTOCK, 16'd0);
      send_request(CMD_DISPENSE, 16'hFFFF);   // needs more large coins than stocked
      send_request(CMD_DISPENSE, 16'd3);      // below the smallest coin
      send_request(CMD_DISPENSE, 16'd1885);   // every denomination used once
      send_request(CMD_DEPOSIT, 16'd5);
      send_request(CMD_DEPOSIT, 16'd1000);
      wait_drained();
      send_request(CMD_DISPENSE, 16'd4);
      send_request(CMD_DEPOSIT, 16'hFFFF);
      send_request(CMD_DISPENSE, 16'd18888);  // deep payout with a leftover
      run_random(35);

      // Extreme values from 1 up to 4095; the sender idles about half the time.
      sender_idle_pct = 49;
      load_denoms({12'd4095, 12'd2048, 12'd1024, 12'd255, 12'd60, 12'd7, 12'd3, 12'd1});
      run_random(35);

      // Unordered set with zero and duplicate registers, no idling.
      // A few coins of the duplicated value go to the lowest matching register.
      sender_idle_pct = 0;
      load_denoms({12'd300, 12'd13, 12'd4095, 12'd25, 12'd0, 12'd7, 12'd0, 12'd13});
      send_request(CMD_RESTOCK, 16'd0);
      repeat (EXTRA_DEPOSITS) send_request(CMD_DEPOSIT, 16'd13);
      run_random(30);

      // No usable denomination at all: the leftover is the clamped amount.
      load_denoms('0);
      send_request(CMD_DISPENSE, 16'hFFFF);
      send_request(CMD_DISPENSE, 16'd4095);
      send_request(CMD_DISPENSE, 16'd0);
      send_request(CMD_DEPOSIT, 16'd0);
      send_request(CMD_RESTOCK, 16'hFFFF);

      // Drain, then give stray results time to show up.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
